/* src/rkpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rkpm_pkg
// Shared widths, codes and types for the key polyphony manager.
// ----------------------------------------------------------------------------
package rkpm_pkg;

  localparam int ITEM_W  = 7;
  localparam int COUNT_W = 8;
  localparam int RANK_W  = 7;
  localparam int ACT_W   = 2;
  localparam int CFG_W   = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;
  localparam logic [RANK_W-1:0]  RANK_MAX   = 7'd127;
  localparam logic [CFG_W-1:0]   POLY_RESET = 7'd5;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAME   = 2'd0,
    ACT_ON     = 2'd1,
    ACT_OFF    = 2'd2,
    ACT_REJECT = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    REG_POLYPHONY   = 1'b0,
    REG_POLY_ENABLE = 1'b1
  } reg_index_t;

  // one table entry: request count and age rank of an item
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [RANK_W-1:0]  rank;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SWEEP,
    S_FINISH,
    S_STEAL
  } state_t;

endpackage
`default_nettype wire

/* src/rkpm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rkpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rkpm_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/refcounted_key_polyphony_manager.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_key_polyphony_manager
// Per-key request counting with oldest-key stealing under a polyphony limit.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  request  | start, busy               | item_number, request_on
//  result   | result_strobe             | item_id, action, request_count,
//           |                           | last_result
//  config   | cfg_write                 | cfg_index, cfg_data
//
// A rejected item returns its result in the cycle after start, busy stays low.
// A count-only change goes from IDLE through READ and back; a switch-on or
// a release of a ranked key in keys mode walks every table entry once
// through the single RAM port pair in SWEEP, then FINISH, and STEAL when a
// key is stolen. Reset clears the table through per-entry valid bits.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module refcounted_key_polyphony_manager
  import rkpm_pkg::*;
#(
  parameter int NUM_ITEMS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [ITEM_W-1:0]  item_number,
  input  wire logic               request_on,
  output logic                    result_strobe,
  output logic      [ITEM_W-1:0]  item_id,
  output logic      [ACT_W-1:0]   action,
  output logic      [COUNT_W-1:0] request_count,
  output logic                    last_result,
  input  wire logic               cfg_write,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  localparam int IDX_W   = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int CNT_W   = $clog2(NUM_ITEMS + 1);
  localparam int ENTRY_W = COUNT_W + RANK_W;

  state_t state, state_next;

  logic [CFG_W-1:0] polyphony;
  logic             polyphony_enable;

  // latched request
  logic [ITEM_W-1:0] num_q;
  logic              on_q;
  logic [IDX_W-1:0]  idx_q;

  // sweep control
  logic              release_q;
  logic [RANK_W-1:0] rel_rank_q;
  logic [CNT_W-1:0]  sweep_addr;
  logic              pipe_vld;
  logic [IDX_W-1:0]  pipe_addr;
  logic              victim_found;
  logic [IDX_W-1:0]  victim_idx;
  logic [RANK_W-1:0] victim_rank;

  logic [NUM_ITEMS-1:0] valid_bits;
  logic                 rd_valid;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               res_load;
  logic [ITEM_W-1:0]  res_id;
  action_t            res_act;
  logic [COUNT_W-1:0] res_cnt;
  logic               res_last;
  action_t            act_q;

  entry_t             cur;
  logic [IDX_W-1:0]   in_idx;
  logic               in_range;
  logic               accept;
  logic               sweep_go;
  logic [COUNT_W-1:0] cnt_dec;
  logic [COUNT_W-1:0] cnt_inc;
  logic [RANK_W-1:0]  sw_new;
  logic               sw_skip;
  logic               sw_take;
  logic               sweep_last;

  rkpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_ITEMS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entries never written since reset read as zero
  assign cur      = rd_valid ? entry_t'(ram_rdata) : '0;
  assign in_idx   = IDX_W'(item_number - ITEM_W'(1));
  assign in_range = (item_number != '0) && (item_number <= ITEM_W'(NUM_ITEMS));
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;

  assign cnt_dec = cur.count - COUNT_W'(1);
  assign cnt_inc = (cur.count == COUNT_MAX) ? cur.count : cur.count + COUNT_W'(1);

  assign sweep_go = polyphony_enable &&
                    (on_q ? (cur.count == '0)
                          : (cur.count == COUNT_W'(1) && cur.rank != '0));

  // one entry per cycle through the shared rank update
  always_comb begin
    if (release_q) begin
      sw_new = (cur.rank > rel_rank_q) ? cur.rank - RANK_W'(1) : cur.rank;
    end else begin
      sw_new = (cur.rank != '0 && cur.rank != RANK_MAX) ? cur.rank + RANK_W'(1)
                                                        : cur.rank;
    end
  end

  assign sw_skip    = (pipe_addr == idx_q);
  assign sw_take    = pipe_vld && !release_q && !sw_skip &&
                      (sw_new > RANK_W'(polyphony)) && (sw_new > victim_rank);
  assign sweep_last = pipe_vld && (pipe_addr == IDX_W'(NUM_ITEMS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_range) state_next = S_READ;
      end
      S_READ: begin
        state_next = sweep_go ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        if (sweep_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = (!release_q && victim_found) ? S_STEAL : S_IDLE;
      end
      S_STEAL: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs: table access and result
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_raddr = sweep_addr[IDX_W-1:0];
    res_load  = 1'b0;
    res_id    = num_q;
    res_act   = ACT_SAME;
    res_cnt   = '0;
    res_last  = 1'b1;
    case (state)
      S_IDLE: begin
        ram_raddr = in_idx;
        if (accept && !in_range) begin
          res_load = 1'b1;
          res_id   = item_number;
          res_act  = ACT_REJECT;
        end
      end
      S_READ: begin
        if (!sweep_go) begin
          res_load = 1'b1;
          if (!on_q) begin
            if (cur.count == '0) begin
              res_act = ACT_SAME;
            end else if (cur.count != COUNT_W'(1)) begin
              ram_we    = 1'b1;
              ram_wdata = '{count: cnt_dec, rank: cur.rank};
              res_cnt   = cnt_dec;
            end else begin
              ram_we  = 1'b1;
              res_act = ACT_OFF;
            end
          end else begin
            if (cur.count != '0) begin
              ram_we    = 1'b1;
              ram_wdata = '{count: cnt_inc, rank: cur.rank};
              res_cnt   = cnt_inc;
            end else begin
              // stops mode: no aging
              ram_we    = 1'b1;
              ram_wdata = '{count: COUNT_W'(1), rank: RANK_W'(1)};
              res_act   = ACT_ON;
              res_cnt   = COUNT_W'(1);
            end
          end
        end
      end
      S_SWEEP: begin
        ram_waddr = pipe_addr;
        ram_wdata = '{count: cur.count, rank: sw_new};
        ram_we    = pipe_vld && !sw_skip;
      end
      S_FINISH: begin
        ram_we   = 1'b1;
        res_load = 1'b1;
        if (release_q) begin
          res_act = ACT_OFF;
        end else begin
          ram_wdata = '{count: COUNT_W'(1), rank: RANK_W'(1)};
          res_act   = ACT_ON;
          res_cnt   = COUNT_W'(1);
          res_last  = !victim_found;
        end
      end
      S_STEAL: begin
        ram_we    = 1'b1;
        ram_waddr = victim_idx;
        res_load  = 1'b1;
        res_id    = ITEM_W'(victim_idx) + ITEM_W'(1);
        res_act   = ACT_OFF;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      polyphony        <= POLY_RESET;
      polyphony_enable <= 1'b1;
      valid_bits       <= '0;
      rd_valid         <= 1'b0;
      result_strobe    <= 1'b0;
      pipe_vld         <= 1'b0;
      sweep_addr       <= '0;
      victim_found     <= 1'b0;
      victim_rank      <= '0;
    end else begin
      state         <= state_next;
      result_strobe <= res_load;
      rd_valid      <= valid_bits[ram_raddr];
      if (ram_we) valid_bits[ram_waddr] <= 1'b1;
      if (cfg_write) begin
        case (cfg_index)
          REG_POLYPHONY:   polyphony        <= cfg_data;
          REG_POLY_ENABLE: polyphony_enable <= cfg_data[0];
          default:         polyphony        <= polyphony;
        endcase
      end
      if (state == S_READ && sweep_go) begin
        sweep_addr   <= '0;
        pipe_vld     <= 1'b0;
        victim_found <= 1'b0;
        victim_rank  <= '0;
      end else if (state == S_SWEEP) begin
        if (sweep_addr < CNT_W'(NUM_ITEMS)) begin
          sweep_addr <= sweep_addr + CNT_W'(1);
          pipe_vld   <= 1'b1;
        end else begin
          pipe_vld <= 1'b0;
        end
        if (sw_take) begin
          victim_found <= 1'b1;
          victim_rank  <= sw_new;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      num_q <= item_number;
      on_q  <= request_on;
      idx_q <= in_idx;
    end
    if (state == S_READ) begin
      release_q  <= !on_q;
      rel_rank_q <= cur.rank;
    end
    pipe_addr <= sweep_addr[IDX_W-1:0];
    if (sw_take) victim_idx <= pipe_addr;
    if (res_load) begin
      item_id       <= res_id;
      act_q         <= res_act;
      request_count <= res_cnt;
      last_result   <= res_last;
    end
  end

  assign action = act_q;

  // a non-final result is always followed by the stolen key going off
  a_steal_follows: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_result |=>
      result_strobe && last_result && action == ACT_OFF)
    else $error("switch-on result not followed by forced-off result");

  // the sweep never rewrites the requested item's own entry
  a_sweep_skips_own: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP && ram_we |-> ram_waddr != idx_q)
    else $error("sweep wrote the requested item");

  // sweep read and write-back never collide on one entry
  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP && ram_we |-> ram_waddr != ram_raddr)
    else $error("table read and write at the same entry");

  // a switched-on item reports count one
  a_on_count: assert property (@(posedge clk) disable iff (rst)
    result_strobe && action == ACT_ON |-> request_count == COUNT_W'(1))
    else $error("switch-on with count other than one");

  // a new item is only taken with no result pending
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> state == S_IDLE && !pipe_vld)
    else $error("item accepted while sequencer active");

endmodule
`default_nettype wire

/* sim/refcounted_key_polyphony_manager_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_key_polyphony_manager_tb
// Self-checking bench for the key polyphony manager. Requests go in on the
// start/busy port and are mirrored by a local key table model that queues
// the results each item should produce; every strobed result is checked
// against the oldest queued one. A short table of directed items and a
// count saturation burst come first, then randomized phases under a range
// of polyphony limits in both keys and stops mode.
// ----------------------------------------------------------------------------
module refcounted_key_polyphony_manager_tb;
  import rkpm_pkg::*;

  localparam int N_KEYS   = 64;
  localparam int N_PHASES = 8;
  localparam int PHASE_LEN = 177;

  typedef struct packed {
    logic [ITEM_W-1:0]  id;
    action_t            act;
    logic [COUNT_W-1:0] cnt;
    logic               last;
  } key_result_t;

  typedef struct packed {
    logic [ITEM_W-1:0] num;
    logic              on;
    logic              typed;
    key_result_t       want;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [ITEM_W-1:0]  item_number;
  logic               request_on;
  logic               result_strobe;
  logic [ITEM_W-1:0]  item_id;
  logic [ACT_W-1:0]   action;
  logic [COUNT_W-1:0] request_count;
  logic               last_result;
  logic               cfg_write;
  logic [0:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  refcounted_key_polyphony_manager #(.NUM_ITEMS(N_KEYS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item_number(item_number), .request_on(request_on),
    .result_strobe(result_strobe), .item_id(item_id), .action(action),
    .request_count(request_count), .last_result(last_result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the key table and mode
  logic [COUNT_W-1:0] key_count [N_KEYS];
  logic [RANK_W-1:0]  key_rank  [N_KEYS];
  logic [CFG_W-1:0]   poly_limit;
  logic               limit_on;

  key_result_t step_results [$];
  key_result_t pending_results [$];
  key_result_t head_result;

  int errors;
  int n_requests;
  int n_checked;
  int n_stolen;
  int n_rejected;
  int n_settings;

  dir_row_t dir_rows [15] = '{
    '{7'd0,   1'b1, 1'b1, '{7'd0,   ACT_REJECT, 8'd0, 1'b1}},
    '{7'd127, 1'b0, 1'b1, '{7'd127, ACT_REJECT, 8'd0, 1'b1}},
    '{7'd65,  1'b1, 1'b1, '{7'd65,  ACT_REJECT, 8'd0, 1'b1}},
    '{7'd64,  1'b0, 1'b1, '{7'd64,  ACT_SAME,   8'd0, 1'b1}},
    '{7'd1,   1'b1, 1'b1, '{7'd1,   ACT_ON,     8'd1, 1'b1}},
    '{7'd64,  1'b1, 1'b1, '{7'd64,  ACT_ON,     8'd1, 1'b1}},
    '{7'd1,   1'b1, 1'b0, '0},
    '{7'd2,   1'b1, 1'b0, '0},
    '{7'd3,   1'b1, 1'b0, '0},
    '{7'd4,   1'b1, 1'b0, '0},
    '{7'd5,   1'b1, 1'b0, '0},  // sixth key sounding: oldest goes
    '{7'd6,   1'b1, 1'b0, '0},
    '{7'd3,   1'b0, 1'b0, '0},  // release from the middle of the ranks
    '{7'd1,   1'b0, 1'b0, '0},  // stolen key, count already cleared
    '{7'd6,   1'b0, 1'b0, '0}
  };

  logic [CFG_W-1:0] phase_poly [N_PHASES] = '{7'd3, 7'd1, 7'd0, 7'd64, 7'd127, 7'd10, 7'd2, 7'd5};
  logic             phase_en   [N_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Computes the results of one request and updates the local key table.
  function automatic void predict_key_request(input logic [ITEM_W-1:0] num, input logic on);
    int idx;
    int victim;
    logic [RANK_W-1:0] r;
    logic [RANK_W-1:0] vrank;
    bit found;

    step_results.delete();
    if (num == 0 || num > N_KEYS) begin
      step_results.push_back('{num, ACT_REJECT, 8'd0, 1'b1});
      return;
    end
    idx = num - 1;

    if (!on) begin
      if (key_count[idx] == 0) begin
        step_results.push_back('{num, ACT_SAME, 8'd0, 1'b1});
        return;
      end
      key_count[idx] = key_count[idx] - 1'b1;
      if (key_count[idx] != 0) begin
        step_results.push_back('{num, ACT_SAME, key_count[idx], 1'b1});
        return;
      end
      r = key_rank[idx];
      if (limit_on && r != 0) begin
        for (int i = 0; i < N_KEYS; i++) begin
          if (i != idx && key_rank[i] > r) key_rank[i] = key_rank[i] - 1'b1;
        end
      end
      key_rank[idx] = '0;
      step_results.push_back('{num, ACT_OFF, 8'd0, 1'b1});
      return;
    end

    if (key_count[idx] != 0) begin
      if (key_count[idx] < COUNT_MAX) key_count[idx] = key_count[idx] + 1'b1;
      step_results.push_back('{num, ACT_SAME, key_count[idx], 1'b1});
      return;
    end

    key_count[idx] = 8'd1;
    key_rank[idx] = '0;
    if (limit_on) begin
      found = 1'b0;
      victim = 0;
      vrank = '0;
      // age everything, then pick the oldest over the limit (lowest key on a tie)
      for (int i = 0; i < N_KEYS; i++) begin
        if (key_rank[i] > 0 && key_rank[i] < RANK_MAX) key_rank[i] = key_rank[i] + 1'b1;
        if (key_rank[i] > poly_limit && key_rank[i] > vrank) begin
          vrank = key_rank[i];
          victim = i;
          found = 1'b1;
        end
      end
      key_rank[idx] = 7'd1;
      if (found) begin
        key_rank[victim] = '0;
        key_count[victim] = '0;
        n_stolen++;
        step_results.push_back('{num, ACT_ON, 8'd1, 1'b0});
        step_results.push_back('{ITEM_W'(victim + 1), ACT_OFF, 8'd0, 1'b1});
        return;
      end
    end else begin
      key_rank[idx] = 7'd1;
    end
    step_results.push_back('{num, ACT_ON, 8'd1, 1'b1});
  endfunction

  function automatic int pick_gap(input bit steady);
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Entered and left at a falling edge; start stays high after acceptance.
  task automatic send_request(input logic [ITEM_W-1:0] num, input logic on, input int gap,
                              input bit typed, input key_result_t want);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_number = num;
    request_on = on;
    start = 1'b1;
    do @(posedge clk); while (busy);
    n_requests++;
    predict_key_request(num, on);
    if (step_results[0].act == ACT_REJECT) n_rejected++;
    if (typed) pending_results.push_back(want);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
    @(negedge clk);
  endtask

  task automatic settle_idle();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (N_KEYS + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_mode(input logic [CFG_W-1:0] poly, input logic en);
    cfg_write = 1'b1;
    cfg_index = REG_POLYPHONY;
    cfg_data = poly;
    @(negedge clk);
    poly_limit = poly;
    cfg_index = REG_POLY_ENABLE;
    cfg_data = {6'($urandom_range(0, 63)), en};  // upper bits are don't-care
    @(negedge clk);
    limit_on = en;
    cfg_write = 1'b0;
    n_settings++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: id=%0d action=%0d count=%0d last=%0b",
                 $time, item_id, action, request_count, last_result);
      end else begin
        head_result = pending_results.pop_front();
        n_checked++;
        if (item_id !== head_result.id || action !== head_result.act ||
            request_count !== head_result.cnt || last_result !== head_result.last) begin
          errors++;
          $display("%0t: mismatch: expected id=%0d action=%0d count=%0d last=%0b",
                   $time, head_result.id, head_result.act, head_result.cnt, head_result.last);
          $display("%0t:           actual   id=%0d action=%0d count=%0d last=%0b",
                   $time, item_id, action, request_count, last_result);
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("FAIL refcounted_key_polyphony_manager");
    $finish;
  end

  initial begin
    logic [ITEM_W-1:0] num;
    logic [CFG_W-1:0]  poly;
    logic              en;
    int pool_lo;
    int pool_w;
    int p;
    bit steady;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    item_number = '0;
    request_on = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_POLYPHONY;
    cfg_data = '0;
    errors = 0;
    n_requests = 0;
    n_checked = 0;
    n_stolen = 0;
    n_rejected = 0;
    n_settings = 0;
    foreach (key_count[i]) key_count[i] = '0;
    foreach (key_rank[i]) key_rank[i] = '0;
    poly_limit = POLY_RESET;
    limit_on = 1'b1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].num, dir_rows[i].on, pick_gap(1'b0),
                   dir_rows[i].typed, dir_rows[i].want);

    // push one key past the 255 count ceiling and back down to release
    repeat (258) send_request(7'd9, 1'b1, 0, 1'b0, '0);
    repeat (258) send_request(7'd9, 1'b0, 0, 1'b0, '0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle_idle();
      if (ph == N_PHASES - 1) begin
        poly = CFG_W'($urandom_range(1, 64));
        en = 1'($urandom_range(0, 1));
      end else begin
        poly = phase_poly[ph];
        en = phase_en[ph];
      end
      set_mode(poly, en);
      // key pool a little wider than the limit so stealing stays busy
      if (poly >= 60) pool_w = N_KEYS;
      else pool_w = (poly + $urandom_range(2, 12) > N_KEYS) ? N_KEYS : poly + $urandom_range(2, 12);
      if (pool_w < 4) pool_w = 4;
      pool_lo = $urandom_range(1, N_KEYS - pool_w + 1);
      steady = (ph % 3 == 1);
      for (int k = 0; k < PHASE_LEN; k++) begin
        p = $urandom_range(0, 99);
        if (p < 2) num = '0;
        else if (p < 5) num = ITEM_W'($urandom_range(N_KEYS + 1, 127));
        else if (p < 10) num = ITEM_W'($urandom_range(1, N_KEYS));
        else num = ITEM_W'(pool_lo + $urandom_range(0, pool_w - 1));
        send_request(num, $urandom_range(0, 99) < 58, pick_gap(steady), 1'b0, '0);
      end
    end

    settle_idle();
    $display("%0d requests, %0d results checked, %0d keys stolen, %0d rejected",
             n_requests, n_checked, n_stolen, n_rejected);
    $display("%0d limit settings incl. 0, 1, 64 and 127, keys and stops mode", n_settings);
    if (errors == 0) begin
      $display("PASS refcounted_key_polyphony_manager");
    end else begin
      $display("FAIL refcounted_key_polyphony_manager");
    end
    $finish;
  end

endmodule
